>>> rtl/krt_pkg.sv
package krt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CAP_W       = 5;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 64;
	localparam int ST_W        = 3;
	localparam int PC_W        = 3;
	localparam int COND_W      = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BADARG   = 3'd1;
	localparam logic [ST_W-1:0] ST_EXISTS   = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	// microprogram steps
	localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
	localparam logic [PC_W-1:0] STEP_CHECK  = 3'd1;
	localparam logic [PC_W-1:0] STEP_SCAN   = 3'd2;
	localparam logic [PC_W-1:0] STEP_DRAIN  = 3'd3;
	localparam logic [PC_W-1:0] STEP_DECIDE = 3'd4;

	// jump conditions
	localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
	localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd1;
	localparam logic [COND_W-1:0] COND_BAD      = 3'd2;
	localparam logic [COND_W-1:0] COND_MORE     = 3'd3;
	localparam logic [COND_W-1:0] COND_RSP_BUSY = 3'd4;

	typedef struct packed {
		logic                     cmd;
		logic signed [KEY_W-1:0]  key;
		logic        [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] found_value;
	} rsp_t;

	typedef struct packed {
		logic              load;
		logic              check;
		logic              scan;
		logic              decide;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
		logic              ret;
	} ucode_t;

	typedef struct packed {
		logic no_req;
		logic bad;
		logic more;
		logic rsp_busy;
	} flags_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] step);
		ucode_t w;
		w = '0;
		unique case (step)
			STEP_IDLE: begin
				w.load   = 1'b1;
				w.cond   = COND_NO_REQ;
				w.target = STEP_IDLE;
			end
			STEP_CHECK: begin
				w.check  = 1'b1;
				w.cond   = COND_BAD;
				w.target = STEP_DECIDE;
			end
			STEP_SCAN: begin
				w.scan   = 1'b1;
				w.cond   = COND_MORE;
				w.target = STEP_SCAN;
			end
			STEP_DRAIN: begin
				w.cond   = COND_NEVER;
				w.target = STEP_IDLE;
			end
			STEP_DECIDE: begin
				w.decide = 1'b1;
				w.cond   = COND_RSP_BUSY;
				w.target = STEP_DECIDE;
				w.ret    = 1'b1;
			end
			default: begin
				w.cond   = COND_NEVER;
				w.target = STEP_IDLE;
				w.ret    = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/keyed_registry_table_core.sv
// Key/value table of TABLE_DEPTH slots; a clear valid bit marks an empty slot. A lookup
// (cmd 0) returns the value stored under the key or not found; an insert (cmd 1)
// fills the first empty slot, answers ok for a same-valued duplicate, already exists
// for a different value, or table full. Capacity zero, key zero, or an insert of
// value zero answers bad argument. After acceptance the key memory is scanned one
// slot per cycle by a small microprogram, over capacity_in_use slots saturated to
// TABLE_DEPTH; a bad argument skips the scan. A new request is taken only while
// the sequencer is idle, but a finished result may wait in the output register
// meanwhile. The table is empty right after reset; no clearing pass is needed.
// capacity_in_use must be written only while the block is idle; the block itself
// does not enforce this.
module keyed_registry_table_core #(
	parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [krt_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  krt_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output krt_pkg::rsp_t              rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EW = ($clog2(TABLE_DEPTH + 1) > krt_pkg::CAP_W) ?
		$clog2(TABLE_DEPTH + 1) : krt_pkg::CAP_W;

	krt_pkg::ucode_t ctl;
	krt_pkg::flags_t flags;

	logic [krt_pkg::CAP_W-1:0] cap_q;
	logic [EW-1:0]             cap_ext;
	logic [EW-1:0]             depth_ext;
	logic [EW-1:0]             eff_cap;
	logic [IW-1:0]             last_idx;

	krt_pkg::req_t             req_q;
	logic [IW-1:0]             idx_q;
	logic                      pend_s1;
	logic [IW-1:0]             pidx_s1;
	logic                      rd_vld_s1;
	logic                      hit_q;
	logic                      emp_q;
	logic [IW-1:0]             emp_idx_q;
	logic                      bad_q;
	logic [TABLE_DEPTH-1:0]    vld_q;

	logic [krt_pkg::KEY_W-1:0] key_rdata;
	logic [krt_pkg::VAL_W-1:0] val_rdata;
	logic                      key_match;
	logic                      val_re;
	logic                      bad;
	logic                      fire;
	logic                      ins_new;
	logic                      rsp_busy;
	krt_pkg::rsp_t             res;
	logic                      rsp_valid_q;
	krt_pkg::rsp_t             rsp_q;

	krt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	assign cap_ext   = EW'(cap_q);
	assign depth_ext = EW'(TABLE_DEPTH);
	assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
	assign last_idx  = IW'(eff_cap - EW'(1));

	assign bad = (eff_cap == '0) || (req_q.key == '0) ||
		((req_q.cmd == krt_pkg::CMD_INSERT) && (req_q.value == '0));

	assign rsp_busy = rsp_valid_q && rsp_stall;
	assign req_stall = !ctl.load;

	assign flags.no_req   = !req_valid;
	assign flags.bad      = bad;
	assign flags.more     = (idx_q != last_idx);
	assign flags.rsp_busy = rsp_busy;

	assign key_match = rd_vld_s1 && (key_rdata == $unsigned(req_q.key));
	assign val_re    = pend_s1 && key_match && !hit_q;

	assign fire    = ctl.decide && !rsp_busy;
	assign ins_new = fire && !bad_q && (req_q.cmd == krt_pkg::CMD_INSERT) && !hit_q && emp_q;

	krt_ram #(
		.WIDTH (krt_pkg::KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (ins_new),
		.waddr (emp_idx_q),
		.wdata ($unsigned(req_q.key)),
		.re    (ctl.scan),
		.raddr (idx_q),
		.rdata (key_rdata)
	);

	krt_ram #(
		.WIDTH (krt_pkg::VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_val_ram (
		.clk   (clk),
		.we    (ins_new),
		.waddr (emp_idx_q),
		.wdata (req_q.value),
		.re    (val_re),
		.raddr (pidx_s1),
		.rdata (val_rdata)
	);

	always_comb begin
		res = '0;
		priority if (bad_q) begin
			res.status = krt_pkg::ST_BADARG;
		end else if (req_q.cmd == krt_pkg::CMD_LOOKUP) begin
			if (hit_q) begin
				res.status      = krt_pkg::ST_OK;
				res.found_value = val_rdata;
			end else begin
				res.status = krt_pkg::ST_NOTFOUND;
			end
		end else if (hit_q) begin
			res.status = (val_rdata == req_q.value) ? krt_pkg::ST_OK : krt_pkg::ST_EXISTS;
		end else if (emp_q) begin
			res.status = krt_pkg::ST_OK;
		end else begin
			res.status = krt_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= krt_pkg::CAP_RESET;
			vld_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			emp_q       <= 1'b0;
			bad_q       <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			pend_s1 <= ctl.scan;
			if (ctl.check) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				emp_q <= 1'b0;
				bad_q <= bad;
			end
			if (ctl.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			// keep the first match and the first empty slot
			if (pend_s1) begin
				if (key_match) begin
					hit_q <= 1'b1;
				end
				if (!rd_vld_s1 && !emp_q) begin
					emp_q <= 1'b1;
				end
			end
			if (ins_new) begin
				vld_q[emp_idx_q] <= 1'b1;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && req_valid) begin
			req_q <= req;
		end
		if (ctl.scan) begin
			pidx_s1   <= idx_q;
			rd_vld_s1 <= vld_q[idx_q];
		end
		if (pend_s1 && !rd_vld_s1 && !emp_q) begin
			emp_idx_q <= pidx_s1;
		end
		if (fire) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_found_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == krt_pkg::ST_OK || rsp.found_value == '0))
		else $error("found_value set on a failed transaction");

	a_slots_never_freed: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((vld_q & $past(vld_q)) == $past(vld_q)))
		else $error("occupied slot lost its key");

	a_write_to_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ins_new |-> (emp_q && !vld_q[emp_idx_q]))
		else $error("insert targets an occupied slot");

endmodule

>>> rtl/krt_ram.sv
module krt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/krt_seq.sv
module krt_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  krt_pkg::flags_t flags,
	output krt_pkg::ucode_t ctl
);

	logic [krt_pkg::PC_W-1:0] pc_q;
	logic                     take;

	assign ctl = krt_pkg::ucode_rom(pc_q);

	always_comb begin
		unique case (ctl.cond)
			krt_pkg::COND_NEVER:    take = 1'b0;
			krt_pkg::COND_NO_REQ:   take = flags.no_req;
			krt_pkg::COND_BAD:      take = flags.bad;
			krt_pkg::COND_MORE:     take = flags.more;
			krt_pkg::COND_RSP_BUSY: take = flags.rsp_busy;
			default:                take = 1'b0;
		endcase
	end

	// jump when the condition holds, else fall through or return to the idle step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= krt_pkg::STEP_IDLE;
		end else if (take) begin
			pc_q <= ctl.target;
		end else if (ctl.ret) begin
			pc_q <= krt_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

>>> test/tb_keyed_registry_table_core.sv
module tb_keyed_registry_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int REPORT_LIMIT   = 10;
	localparam int POOL_SIZE      = 24;
	localparam int PHASE_ITEMS    = 163;
	localparam int PHASE_COUNT    = 10;

	class table_scoreboard;
		logic [krt_pkg::KEY_W-1:0] slot_key[krt_pkg::TABLE_DEPTH];
		logic [krt_pkg::VAL_W-1:0] slot_value[krt_pkg::TABLE_DEPTH];
		logic [krt_pkg::CAP_W-1:0] capacity;
		krt_pkg::rsp_t             expected_q[$];
		int                        failures;
		int                        checked;
		int                        requests;
		int                        inserts;
		int                        status_seen[8];

		function new();
			capacity = krt_pkg::CAP_RESET;
			foreach (slot_key[i]) begin
				slot_key[i]   = '0;
				slot_value[i] = '0;
			end
			foreach (status_seen[i])
				status_seen[i] = 0;
			failures = 0;
			checked  = 0;
			requests = 0;
			inserts  = 0;
		endfunction

		function int find_slot(logic [krt_pkg::KEY_W-1:0] k, int limit);
			for (int i = 0; i < limit; i++)
				if (slot_key[i] == k)
					return i;
			return -1;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(krt_pkg::req_t r);
			krt_pkg::rsp_t answer;
			int            limit;
			int            hit;
			int            empty;
			answer   = '0;
			limit    = (capacity > krt_pkg::TABLE_DEPTH) ? krt_pkg::TABLE_DEPTH : int'(capacity);
			requests++;
			if (r.cmd == krt_pkg::CMD_INSERT)
				inserts++;
			if (limit == 0 || r.key == '0 ||
				(r.cmd == krt_pkg::CMD_INSERT && r.value == '0)) begin
				answer.status = krt_pkg::ST_BADARG;
			end else begin
				hit = find_slot(r.key, limit);
				if (r.cmd == krt_pkg::CMD_LOOKUP) begin
					if (hit >= 0) begin
						answer.status      = krt_pkg::ST_OK;
						answer.found_value = slot_value[hit];
					end else begin
						answer.status = krt_pkg::ST_NOTFOUND;
					end
				end else if (hit >= 0) begin
					answer.status = (slot_value[hit] == r.value) ?
						krt_pkg::ST_OK : krt_pkg::ST_EXISTS;
				end else begin
					empty = find_slot('0, limit);
					if (empty >= 0) begin
						slot_key[empty]   = r.key;
						slot_value[empty] = r.value;
						answer.status     = krt_pkg::ST_OK;
					end else begin
						answer.status = krt_pkg::ST_FULL;
					end
				end
			end
			status_seen[answer.status]++;
			expected_q.push_back(answer);
		endfunction

		function void check_response(krt_pkg::rsp_t got);
			krt_pkg::rsp_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected response: status %0d found_value %h",
						got.status, got.found_value);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.status !== want.status || got.found_value !== want.found_value) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("response %0d: status expected %0d got %0d, found_value expected %h got %h",
						checked, want.status, got.status, want.found_value, got.found_value);
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [krt_pkg::CAP_W-1:0] cfg_wdata;
	logic                      req_valid;
	logic                      req_stall;
	krt_pkg::req_t             req;
	logic                      rsp_valid;
	logic                      rsp_stall;
	krt_pkg::rsp_t             rsp;

	table_scoreboard           tracker;
	logic [krt_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
	bit                        send_quiet;
	bit                        recv_quiet;
	int                        stall_left;
	int                        idle_cycles;
	int                        capacity_writes;

	keyed_registry_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5ns clk = ~clk;

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic krt_pkg::req_t make_request(logic cmd, logic [krt_pkg::KEY_W-1:0] k,
		logic [krt_pkg::VAL_W-1:0] v);
		krt_pkg::req_t r;
		r.cmd   = cmd;
		r.key   = k;
		r.value = v;
		return r;
	endfunction

	function automatic krt_pkg::req_t random_request();
		krt_pkg::req_t r;
		int            pick;
		r.cmd = 1'($urandom_range(0, 1));
		pick  = $urandom_range(0, 99);
		if (pick < 5)
			r.key = '0;
		else if (pick < 80)
			r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			r.key = $urandom;
		// a value tied to the key makes repeated inserts of the same pair common
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.value = '0;
		else if (pick < 55)
			r.value = {r.key ^ 32'hA5C3_0F96, ~r.key};
		else if (pick < 62)
			r.value = '1;
		else
			r.value = {$urandom, $urandom};
		return r;
	endfunction

	task automatic send_request(krt_pkg::req_t item);
		int gap;
		gap = pick_gap(send_quiet);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tracker.note_request(item);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [krt_pkg::CAP_W-1:0] c);
		wait_for_results();
		// let the sequencer return to idle
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wdata <= c;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.capacity = c;
		capacity_writes++;
	endtask

	// response side: check every accepted transaction, stall in random bursts
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (!recv_quiet && $urandom_range(0, 4) == 0) begin
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_keyed_registry_table_core failed");
		$finish;
	end

	initial begin
		logic [krt_pkg::CAP_W-1:0] phase_caps[PHASE_COUNT];
		tracker         = new();
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		req_valid       = 1'b0;
		req             = '0;
		rsp_stall       = 1'b0;
		stall_left      = 0;
		send_quiet      = 1'b0;
		recv_quiet      = 1'b0;
		capacity_writes = 0;
		phase_caps      = '{5'd1, 5'd3, 5'd8, 5'd0, 5'd17, 5'd31, 5'd2, 5'd12, 5'd16, 5'd5};

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'hFFFF_FFFF;
		key_pool[3] = 32'h0000_0001;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, argument checks, duplicates, capacity limits
		send_request(make_request(krt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, '0));
		send_request(make_request(krt_pkg::CMD_INSERT, '0, 64'h1));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h5, '0));
		send_request(make_request(krt_pkg::CMD_LOOKUP, '0, '1));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h8000_0000, '1));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 64'h1));
		send_request(make_request(krt_pkg::CMD_INSERT, '1, 64'h8000_0000_0000_0000));
		send_request(make_request(krt_pkg::CMD_LOOKUP, 32'h8000_0000, '0));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h8000_0000, '1));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h8000_0000, 64'h2));
		send_request(make_request(krt_pkg::CMD_LOOKUP, '1, '0));
		send_request(make_request(krt_pkg::CMD_LOOKUP, 32'h1, '0));
		send_request(make_request(krt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 64'hDEAD_BEEF_0000_0001));
		write_capacity(5'd0);
		send_request(make_request(krt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, '0));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h9, 64'h9));
		write_capacity(5'd2);
		send_request(make_request(krt_pkg::CMD_LOOKUP, '1, '0));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h9, 64'h9));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 64'h1));
		write_capacity(5'd31);
		send_request(make_request(krt_pkg::CMD_LOOKUP, '1, '0));
		send_request(make_request(krt_pkg::CMD_INSERT, 32'h9, 64'h9));
		send_request(make_request(krt_pkg::CMD_LOOKUP, 32'h9, '0));

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_capacity(phase_caps[p]);
			send_quiet = ($urandom_range(0, 3) == 0);
			recv_quiet = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the sender until the table has answered everything
				if (n == PHASE_ITEMS / 2 && p == PHASE_COUNT / 2)
					wait_for_results();
				send_request(random_request());
			end
		end

		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.pending() != 0) begin
			tracker.failures += tracker.pending();
			$display("%0d responses never arrived", tracker.pending());
		end

		$display("covered %0d requests (%0d inserts) across %0d capacity writes",
			tracker.requests, tracker.inserts, capacity_writes);
		$display("answers: %0d ok, %0d bad argument, %0d already exists, %0d not found, %0d full",
			tracker.status_seen[krt_pkg::ST_OK], tracker.status_seen[krt_pkg::ST_BADARG],
			tracker.status_seen[krt_pkg::ST_EXISTS], tracker.status_seen[krt_pkg::ST_NOTFOUND],
			tracker.status_seen[krt_pkg::ST_FULL]);
		if (tracker.failures == 0)
			$display("tb_keyed_registry_table_core passed");
		else
			$display("tb_keyed_registry_table_core failed");
		$finish;
	end

endmodule
